>>> rtl/core/ggw_pkg.sv
// ----------------------------------------------------------------------------
// ggw_pkg
// Shared types, constants and helpers of the greedy word wrap block.
// ----------------------------------------------------------------------------
package ggw_pkg;

   localparam int LINE_CHARS     = 31;
   localparam int MAX_LINE_SLOTS = 10;

   localparam int CHAR_W  = 8;
   localparam int WIDTH_W = 5;
   localparam int LIMIT_W = 4;
   localparam int COL_W   = 5;
   localparam int LINE_W  = 4;
   localparam int COUNT_W = 4;
   localparam int POS_W   = $clog2(LINE_CHARS);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CHARS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LINES = 1'd1;

   localparam logic [WIDTH_W-1:0] MAX_CHARS_RESET = 5'd31;
   localparam logic [LIMIT_W-1:0] MAX_LINES_RESET = 4'd10;

   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_CHAR,
      OP_SPACE,
      OP_NEWLINE,
      OP_END
   } op_kind_type;

   typedef struct packed {
      op_kind_type             kind;
      logic [CHAR_W-1:0]       ch;
   } op_type;

   typedef struct packed {
      logic                    mode;
      logic [CHAR_W-1:0]       character;
   } req_type;

   typedef struct packed {
      logic [LINE_W-1:0]       line_index;
      logic [COL_W-1:0]        column;
      logic [CHAR_W-1:0]       out_char;
      logic                    has_char;
      logic                    line_end;
      logic                    text_done;
      logic [COUNT_W-1:0]      line_count;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [WIDTH_W-1:0]      max_chars;
      logic [LIMIT_W-1:0]      max_lines;
   } cfg_type;

   function automatic logic [WIDTH_W-1:0] width_clamp(input logic [WIDTH_W-1:0] v);
      logic [WIDTH_W-1:0] r;
      r = v;
      if (r == '0) r = WIDTH_W'(1);
      if (r > WIDTH_W'(LINE_CHARS)) r = WIDTH_W'(LINE_CHARS);
      return r;
   endfunction

   function automatic logic [LIMIT_W-1:0] limit_clamp(input logic [LIMIT_W-1:0] v);
      logic [LIMIT_W-1:0] r;
      r = v;
      if (r == '0) r = LIMIT_W'(1);
      if (r > LIMIT_W'(MAX_LINE_SLOTS)) r = LIMIT_W'(MAX_LINE_SLOTS);
      return r;
   endfunction

endpackage

>>> rtl/core/ggw_front.sv
// ----------------------------------------------------------------------------
// ggw_front
// Takes input words, classifies each byte and holds it for the queue.
// ----------------------------------------------------------------------------
module ggw_front import ggw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    push,
   output op_type  push_op,
   input  logic    queue_full
);

   logic   front_valid_ff, front_valid_in;
   op_type front_op_ff, front_op_in;
   logic   take;
   logic   drop;
   op_type class_op;

   assign req_stall = front_valid_ff && queue_full;
   assign push      = front_valid_ff && !queue_full;
   assign push_op   = front_op_ff;
   assign take      = req_valid && !req_stall;

   always_comb begin
      class_op.ch   = req_data.character;
      class_op.kind = OP_CHAR;
      drop          = 1'b0;
      if (req_data.mode) begin
         class_op.kind = OP_END;
      end else begin
         case (req_data.character) inside
            CHAR_CR:              drop = 1'b1;
            CHAR_LF:              class_op.kind = OP_NEWLINE;
            CHAR_SPACE, CHAR_TAB: class_op.kind = OP_SPACE;
            default:              class_op.kind = OP_CHAR;
         endcase
      end
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      front_op_in    = front_op_ff;
      if (push) front_valid_in = 1'b0;
      // carriage return is simply swallowed here
      if (take) begin
         front_valid_in = !drop;
         front_op_in    = class_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_op_ff <= front_op_in;
   end

endmodule

>>> rtl/core/ggw_queue.sv
// ----------------------------------------------------------------------------
// ggw_queue
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module ggw_queue import ggw_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   pop_valid,
   output op_type pop_op
);

   op_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_op    = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_op;
   end

endmodule

>>> rtl/core/ggw_back.sv
// ----------------------------------------------------------------------------
// ggw_back
// Layout engine: builds words and lines and walks finished lines out.
// ----------------------------------------------------------------------------
module ggw_back import ggw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    op_valid,
   input  op_type  op_in,
   output logic    op_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_APPEND,
      S_COPY,
      S_PUSH,
      S_WCHK,
      S_POST,
      S_FULLCHK,
      S_SUM,
      S_FIN
   } state_type;

   logic [CHAR_W-1:0] line_store_ff [LINE_CHARS];
   logic [CHAR_W-1:0] word_store_ff [LINE_CHARS];

   state_type          state_ff, state_in;
   state_type          ret_ff, ret_in;
   op_type             op_ff, op_next;
   logic [WIDTH_W-1:0] ll_ff, ll_in;
   logic [WIDTH_W-1:0] wl_ff, wl_in;
   logic               ov_ff, ov_in;
   logic [LINE_W-1:0]  lu_ff, lu_in;
   logic               full_ff, full_in;
   logic [POS_W-1:0]   src_ff, src_in;
   logic [POS_W-1:0]   dst_ff, dst_in;
   logic [WIDTH_W-1:0] len_ff, len_in;
   logic [POS_W-1:0]   idx_ff, idx_in;
   logic               hold_v_ff, hold_v_in;
   rsp_type            hold_ff, hold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [WIDTH_W-1:0] width;
   logic [LIMIT_W-1:0] limit;
   logic               at_limit;
   logic               word_long;
   logic [WIDTH_W-1:0] wl_cut;
   logic               word_fits;
   logic               out_free;
   logic               can_emit;
   logic               emit;
   rsp_type            emit_item;
   logic               fin;
   logic               line_we;
   logic [POS_W-1:0]   line_waddr;
   logic [CHAR_W-1:0]  line_wdata;
   logic               word_we;

   assign width     = width_clamp(cfg.max_chars);
   assign limit     = limit_clamp(cfg.max_lines);
   assign at_limit  = lu_ff >= limit;
   assign word_long = ov_ff || (wl_ff > width);
   assign wl_cut    = (wl_ff > width) ? width : wl_ff;
   assign word_fits = ({2'b00, ll_ff} + 7'd1 + {2'b00, wl_ff}) <= {2'b00, width};
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign can_emit  = !hold_v_ff || out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      op_next    = op_ff;
      ll_in      = ll_ff;
      wl_in      = wl_ff;
      ov_in      = ov_ff;
      lu_in      = lu_ff;
      full_in    = full_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      op_pop     = 1'b0;
      emit       = 1'b0;
      emit_item  = '0;
      fin        = 1'b0;
      line_we    = 1'b0;
      line_waddr = dst_ff;
      line_wdata = word_store_ff[src_ff];
      word_we    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               op_pop  = 1'b1;
               op_next = op_in;
               case (op_in.kind) inside
                  OP_CHAR: begin
                     if (!full_ff) begin
                        if (wl_ff < WIDTH_W'(LINE_CHARS)) begin
                           word_we = 1'b1;
                           wl_in   = wl_ff + 1'b1;
                        end else begin
                           ov_in = 1'b1;
                        end
                     end
                  end
                  OP_SPACE, OP_NEWLINE: begin
                     if (!full_ff) state_in = S_APPEND;
                  end
                  OP_END: begin
                     state_in = full_ff ? S_SUM : S_APPEND;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_APPEND: begin
            src_in = '0;
            idx_in = '0;
            if (wl_ff == '0 && !ov_ff) begin
               state_in = S_POST;
            end else if (word_long) begin
               if (ll_ff != '0) begin
                  state_in = S_PUSH;
                  ret_in   = S_WCHK;
               end else begin
                  dst_in   = '0;
                  len_in   = wl_cut;
                  ll_in    = wl_cut;
                  state_in = S_COPY;
               end
            end else if (ll_ff == '0) begin
               dst_in   = '0;
               len_in   = wl_ff;
               ll_in    = wl_ff;
               state_in = S_COPY;
            end else if (word_fits) begin
               line_we    = 1'b1;
               line_waddr = POS_W'(ll_ff);
               line_wdata = CHAR_SPACE;
               dst_in     = POS_W'(ll_ff + 1'b1);
               len_in     = wl_ff;
               ll_in      = ll_ff + 1'b1 + wl_ff;
               state_in   = S_COPY;
            end else begin
               state_in = S_PUSH;
               ret_in   = S_WCHK;
            end
         end

         S_COPY: begin
            line_we = 1'b1;
            src_in  = src_ff + 1'b1;
            dst_in  = dst_ff + 1'b1;
            if (WIDTH_W'(src_ff) == len_ff - 1'b1) begin
               wl_in    = '0;
               ov_in    = 1'b0;
               state_in = S_POST;
            end
         end

         S_PUSH: begin
            if (at_limit) begin
               state_in = ret_ff;
            end else if (ll_ff == '0) begin
               // empty line goes out as a single marker word
               emit                 = 1'b1;
               emit_item.line_index = lu_ff;
               emit_item.line_end   = 1'b1;
               if (can_emit) begin
                  lu_in    = lu_ff + 1'b1;
                  state_in = ret_ff;
               end
            end else begin
               emit                 = 1'b1;
               emit_item.line_index = lu_ff;
               emit_item.column     = COL_W'(idx_ff);
               emit_item.out_char   = line_store_ff[idx_ff];
               emit_item.has_char   = 1'b1;
               emit_item.line_end   = WIDTH_W'(idx_ff) == ll_ff - 1'b1;
               if (can_emit) begin
                  idx_in = idx_ff + 1'b1;
                  if (WIDTH_W'(idx_ff) == ll_ff - 1'b1) begin
                     idx_in   = '0;
                     lu_in    = lu_ff + 1'b1;
                     ll_in    = '0;
                     state_in = ret_ff;
                  end
               end
            end
         end

         S_WCHK: begin
            src_in = '0;
            if (at_limit) begin
               wl_in    = '0;
               ov_in    = 1'b0;
               state_in = S_POST;
            end else begin
               dst_in   = '0;
               len_in   = wl_cut;
               ll_in    = wl_cut;
               state_in = S_COPY;
            end
         end

         S_POST: begin
            idx_in = '0;
            case (op_ff.kind)
               OP_SPACE: state_in = S_FULLCHK;
               OP_NEWLINE: begin
                  state_in = S_PUSH;
                  ret_in   = S_FULLCHK;
               end
               OP_END: begin
                  if (ll_ff != '0 && !at_limit) begin
                     state_in = S_PUSH;
                     ret_in   = S_SUM;
                  end else begin
                     state_in = S_SUM;
                  end
               end
               default: state_in = S_FIN;
            endcase
         end

         S_FULLCHK: begin
            if (at_limit) full_in = 1'b1;
            state_in = S_FIN;
         end

         S_SUM: begin
            emit                 = 1'b1;
            emit_item.text_done  = 1'b1;
            emit_item.line_count = (lu_ff == '0) ? COUNT_W'(1) : COUNT_W'(lu_ff);
            if (can_emit) begin
               ll_in    = '0;
               wl_in    = '0;
               ov_in    = 1'b0;
               lu_in    = '0;
               full_in  = 1'b0;
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            fin = 1'b1;
            if (can_emit) state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // one word is held back so that the final one of an operation can be tagged
   always_comb begin
      hold_v_in    = hold_v_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (emit && can_emit) begin
         if (hold_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = hold_ff;
         end
         hold_v_in = 1'b1;
         hold_in   = emit_item;
      end
      if (fin && hold_v_ff && out_free) begin
         rsp_valid_in     = 1'b1;
         rsp_data_in      = hold_ff;
         rsp_data_in.last = 1'b1;
         hold_v_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_FIN;
         ll_ff        <= '0;
         wl_ff        <= '0;
         ov_ff        <= 1'b0;
         lu_ff        <= '0;
         full_ff      <= 1'b0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         ll_ff        <= ll_in;
         wl_ff        <= wl_in;
         ov_ff        <= ov_in;
         lu_ff        <= lu_in;
         full_ff      <= full_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_next;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (line_we) line_store_ff[line_waddr] <= line_wdata;
      if (word_we) word_store_ff[POS_W'(wl_ff)] <= op_in.ch;
   end

endmodule

>>> rtl/core/greedy_word_wrap.sv
// ----------------------------------------------------------------------------
// greedy_word_wrap
// Greedy word wrap of a character stream into tagged line characters.
// ----------------------------------------------------------------------------
// Input words carry one text byte (mode 0) or an end-of-text mark (mode 1).
// Output words carry one placed character with its line and column, an
// empty-line marker, or the summary word with the line count; last is set
// on the final output word caused by an input word.
// A front stage classifies bytes (carriage return is dropped there) and
// feeds a four-entry queue, so input keeps flowing while the back engine
// walks a line out. The engine takes an ordinary character without leaving
// its idle state. A space copies the pending word, character by character,
// from the word store into the line store; a line break also walks the
// finished line out, one output word per character (one for an empty
// line). End of text does the same, the summary word included, or gives
// only the summary word once the line limit has been reached.
// A stalled output holds its word; the engine keeps one more word in a
// hold register and waits for room, and back pressure then reaches the
// input through the queue. Reset clears all layout state and sets the
// width to 31 and the line limit to 10; stores need no clearing.
// Configuration is written through csr_we, csr_index and csr_wdata.
// ----------------------------------------------------------------------------
module greedy_word_wrap import ggw_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    push;
   op_type  push_op;
   logic    queue_full;
   logic    op_pop;
   logic    op_valid;
   op_type  op_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_CHARS: cfg_in.max_chars = WIDTH_W'(csr_wdata);
            CSR_MAX_LINES: cfg_in.max_lines = LIMIT_W'(csr_wdata);
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_chars <= MAX_CHARS_RESET;
         cfg_ff.max_lines <= MAX_LINES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ggw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_op    (push_op),
      .queue_full (queue_full)
   );

   ggw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .full      (queue_full),
      .pop       (op_pop),
      .pop_valid (op_valid),
      .pop_op    (op_head)
   );

   ggw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .op_valid  (op_valid),
      .op_in     (op_head),
      .op_pop    (op_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
